// File: hdl/ptri_pkg.sv
// ----------------------------------------------------------------------------
// ptri_pkg: shared types and constants of the triangle oscillator
// Holds the channel payload structs, the internal fixed-point value type and
// the constants of the width clamp and the transition polynomials.
// ----------------------------------------------------------------------------
package ptri_pkg;

    // output word width, signed Q2.(OUT_BITS-2)
    localparam int OUT_BITS = 24;

    // internal signed values, 32 fraction bits
    localparam int VAL_BITS  = 56;
    localparam int FRAC_BITS = 32;

    // pulse width clamp, 0.01 and 0.99 in Q0.16
    localparam logic [15:0] WIDTH_MIN = 16'd655;
    localparam logic [15:0] WIDTH_MAX = 16'd64881;

    // divisors of the quartic term in the transition pieces
    localparam logic [3:0] QUARTIC_DIV_MID  = 4'd6;
    localparam logic [3:0] QUARTIC_DIV_EDGE = 4'd12;

    typedef logic signed [VAL_BITS-1:0] val_t;

    typedef struct packed {
        logic        [31:0] phase_increment;
        logic        [31:0] phase_offset;
        logic signed [15:0] sync_level;
        logic        [15:0] pulse_width;
    } ptri_ctrl_t;

    typedef struct packed {
        logic signed [OUT_BITS-1:0] wave_sample;
        logic                       cycle_start;
    } ptri_wave_t;

endpackage

// File: hdl/ptri_div.sv
// ----------------------------------------------------------------------------
// ptri_div: bit-serial restoring divider
// Produces floor(num / den), one quotient bit per cycle, numerator first.
// done pulses for one cycle once quot holds the result.
// ----------------------------------------------------------------------------
module ptri_div #(
    parameter int NUM_BITS = 66,
    parameter int DEN_BITS = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [NUM_BITS-1:0] num,
    input  logic [DEN_BITS-1:0] den,
    output logic                done,
    output logic [NUM_BITS-1:0] quot
);
    import ptri_pkg::*;

    localparam int CNT_BITS = $clog2(NUM_BITS + 1);

    logic [NUM_BITS-1:0] nq_reg;
    logic [DEN_BITS-1:0] rem_reg;
    logic [DEN_BITS-1:0] den_reg;
    logic [CNT_BITS-1:0] cnt_reg;
    logic                busy_reg;
    logic                done_reg;

    logic [DEN_BITS:0]   rem_sh;
    logic [DEN_BITS:0]   rem_sub;
    logic                fits;

    // trial subtract of the shifted remainder
    always_comb
    begin
        rem_sh  = {rem_reg, nq_reg[NUM_BITS-1]};
        rem_sub = rem_sh - {1'b0, den_reg};
        fits    = (rem_sh >= {1'b0, den_reg});
    end

    // control: count the quotient bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_BITS'(NUM_BITS);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_BITS'(1);
                if (cnt_reg == CNT_BITS'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath: shift the numerator out and the quotient in
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            nq_reg  <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            nq_reg  <= {nq_reg[NUM_BITS-2:0], fits};
            rem_reg <= fits ? rem_sub[DEN_BITS-1:0] : rem_sh[DEN_BITS-1:0];
        end
    end

    assign done = done_reg;
    assign quot = nq_reg;

endmodule

// File: hdl/ptri_mul.sv
// ----------------------------------------------------------------------------
// ptri_mul: bit-serial fixed-point multiplier
// Sign-magnitude shift-add multiply of two signed values with 32 fraction
// bits; the product is truncated toward zero back to 32 fraction bits.
// ----------------------------------------------------------------------------
module ptri_mul (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  ptri_pkg::val_t opa,
    input  ptri_pkg::val_t opb,
    output logic           done,
    output ptri_pkg::val_t result
);
    import ptri_pkg::*;

    localparam int MAG_BITS = VAL_BITS - 1;
    localparam int CNT_BITS = $clog2(MAG_BITS + 1);

    logic [MAG_BITS:0]     hi_reg;
    logic [MAG_BITS-1:0]   lo_reg;
    logic [MAG_BITS-1:0]   mcand_reg;
    logic                  neg_reg;
    logic [CNT_BITS-1:0]   cnt_reg;
    logic                  busy_reg;
    logic                  done_reg;

    val_t                  abs_a;
    val_t                  abs_b;
    logic [MAG_BITS:0]     sum;
    logic [2*MAG_BITS-1:0] prod;
    val_t                  mag;

    // magnitudes, partial sum and final scaling
    always_comb
    begin
        abs_a  = opa[VAL_BITS-1] ? -opa : opa;
        abs_b  = opb[VAL_BITS-1] ? -opb : opb;
        sum    = hi_reg + (lo_reg[0] ? {1'b0, mcand_reg} : '0);
        prod   = {hi_reg[MAG_BITS-1:0], lo_reg};
        mag    = $signed({1'b0, prod[MAG_BITS+FRAC_BITS-1:FRAC_BITS]});
        result = neg_reg ? -mag : mag;
    end

    // control: count the multiplier bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_BITS'(MAG_BITS);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_BITS'(1);
                if (cnt_reg == CNT_BITS'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath: add and shift right, one multiplier bit per cycle
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            hi_reg    <= '0;
            lo_reg    <= abs_b[MAG_BITS-1:0];
            mcand_reg <= abs_a[MAG_BITS-1:0];
            neg_reg   <= opa[VAL_BITS-1] ^ opb[VAL_BITS-1];
        end
        else if (busy_reg)
        begin
            hi_reg <= {1'b0, sum[MAG_BITS:1]};
            lo_reg <= {sum[0], lo_reg[MAG_BITS-1:1]};
        end
    end

    assign done = done_reg;

endmodule

// File: hdl/ptr_triangle_oscillator.sv
// ----------------------------------------------------------------------------
// ptr_triangle_oscillator: anti-aliased variable-width triangle oscillator
//
// One control item in on the ctrl channel gives one sample out on the wave
// channel. A transfer happens on a rising edge with valid high and stall low.
// ctrl_stall is low only while no item is in work; the finished sample sits
// in an output register, so the next item is taken and worked on while the
// receiver still stalls the previous sample.
// The work falls on the shared bit-serial divider (one quotient bit per
// cycle) and the shared bit-serial multiplier (one bit per cycle): a
// straight-line sample needs one division and one multiplication, a sample
// in a transition region four divisions and six multiplications. The
// divider works on N = max(66, PHASE_BITS + 32) bits, the multiplier on
// M = 55 magnitude bits.
// Reset clears the phase and the previous offset, arms hard sync and empties
// the output register. A stalled sample holds until it is taken; the block
// then finishes the next item and waits in its rounding step.
// ----------------------------------------------------------------------------
module ptr_triangle_oscillator #(
    parameter int PHASE_BITS = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   ctrl_valid,
    output logic                   ctrl_stall,
    input  ptri_pkg::ptri_ctrl_t   ctrl_data,
    output logic                   wave_valid,
    input  logic                   wave_stall,
    output ptri_pkg::ptri_wave_t   wave_data
);
    import ptri_pkg::*;

    localparam int NUM_BITS = (PHASE_BITS + 32 > 66) ? PHASE_BITS + 32 : 66;
    localparam int DEN_BITS = (PHASE_BITS > 32) ? PHASE_BITS : 32;
    localparam int RND_SH   = FRAC_BITS + 2 - OUT_BITS;

    localparam logic [1:0] SEG_RISE = 2'd0;
    localparam logic [1:0] SEG_MID  = 2'd1;
    localparam logic [1:0] SEG_END  = 2'd2;
    localparam logic [1:0] SEG_LINE = 2'd3;

    localparam val_t ONE_Q     = val_t'(1) <<< FRAC_BITS;
    localparam val_t QUARTER_Q = val_t'(1) <<< (FRAC_BITS - 2);
    localparam val_t HALF_LSB  = val_t'(1) <<< (RND_SH - 1);
    localparam val_t SAT_HI    = (val_t'(1) <<< (OUT_BITS - 1)) - val_t'(1);
    localparam val_t SAT_LO    = -(val_t'(1) <<< (OUT_BITS - 1));

    typedef enum logic [14:0] {
        ST_IDLE  = 15'b000000000000001,
        ST_PHASE = 15'b000000000000010,
        ST_SEG   = 15'b000000000000100,
        ST_SLOPE = 15'b000000000001000,
        ST_LINE  = 15'b000000000010000,
        ST_CMAG  = 15'b000000000100000,
        ST_UDIV  = 15'b000000001000000,
        ST_USQ   = 15'b000000010000000,
        ST_UCUBE = 15'b000000100000000,
        ST_UQUAD = 15'b000001000000000,
        ST_FRAC  = 15'b000010000000000,
        ST_POLY  = 15'b000100000000000,
        ST_CS    = 15'b001000000000000,
        ST_CORR  = 15'b010000000000000,
        ST_ROUND = 15'b100000000000000
    } state_t;

    state_t                  state_reg, state_next;
    logic                    issued_reg;
    ptri_ctrl_t              ctrl_reg;

    logic [PHASE_BITS-1:0]   phase_reg;
    logic [31:0]             prev_off_reg;
    logic                    sync_zero_reg;

    logic [15:0]             wq_reg;
    logic [PHASE_BITS-1:0]   step_reg;
    logic [PHASE_BITS-1:0]   x_reg;
    logic                    first_reg;
    logic [1:0]              seg_reg;
    logic                    use_a_reg;
    logic                    cyc_reg;
    logic [31:0]             s32_reg;
    logic [31:0]             den_reg;
    val_t                    xd_reg;
    val_t                    slope_reg;
    val_t                    y_reg;
    val_t                    c_reg;
    val_t                    u_reg;
    val_t                    u2_reg;
    val_t                    u3_reg;
    val_t                    u4_reg;
    val_t                    t_reg;
    val_t                    poly_reg;
    val_t                    cs_reg;

    ptri_wave_t              wave_reg;
    logic                    wave_valid_reg;

    // phase step signals
    logic [PHASE_BITS+31:0]  inc_ext;
    logic [PHASE_BITS+31:0]  off_ext;
    logic [31:0]             off_delta;
    logic [PHASE_BITS-1:0]   step_raw;
    logic [PHASE_BITS-1:0]   step_c;
    logic [PHASE_BITS-1:0]   pos_c;
    logic                    sync_rise;
    logic [15:0]             wq_c;

    // segment selection signals
    logic [PHASE_BITS-1:0]   wph;
    logic                    first_c;
    logic [PHASE_BITS-1:0]   x_c;
    logic [PHASE_BITS+1:0]   step1;
    logic [PHASE_BITS+1:0]   step2;
    logic [PHASE_BITS+1:0]   step3;
    logic [PHASE_BITS+1:0]   x_ext;
    logic [1:0]              seg_c;
    logic [PHASE_BITS+31:0]  s_ext;
    logic [PHASE_BITS+31:0]  xq_ext;
    logic [34:0]             dc_c;
    logic [34:0]             xd_c;

    // shared units
    logic                    div_start;
    logic [NUM_BITS-1:0]     div_num;
    logic [DEN_BITS-1:0]     div_den;
    logic                    div_done;
    logic [NUM_BITS-1:0]     div_quot;
    val_t                    div_q;
    logic                    mul_start;
    val_t                    mul_a;
    val_t                    mul_b;
    logic                    mul_done;
    val_t                    mul_res;

    // tail signals
    val_t                    poly_c;
    val_t                    rnd_c;
    logic                    wave_free;
    logic                    ctrl_take;
    logic                    div_state;
    logic                    mul_state;

    // phase advance and width clamp
    always_comb
    begin
        inc_ext   = {ctrl_reg.phase_increment, {PHASE_BITS{1'b0}}};
        off_delta = ctrl_reg.phase_offset - prev_off_reg;
        off_ext   = {off_delta, {PHASE_BITS{1'b0}}};
        step_raw  = inc_ext[PHASE_BITS+31:32];
        step_c    = (step_raw == '0) ? PHASE_BITS'(1) : step_raw;
        sync_rise = (ctrl_reg.sync_level != 16'sd0) && !ctrl_reg.sync_level[15]
                    && sync_zero_reg;
        pos_c     = sync_rise ? '0 : phase_reg + off_ext[PHASE_BITS+31:32] + step_c;
        if (ctrl_reg.pulse_width < WIDTH_MIN)
            wq_c = WIDTH_MIN;
        else if (ctrl_reg.pulse_width > WIDTH_MAX)
            wq_c = WIDTH_MAX;
        else
            wq_c = ctrl_reg.pulse_width;
    end

    // half, segment and line offset from the new phase
    always_comb
    begin
        wph     = PHASE_BITS'(wq_reg) << (PHASE_BITS - 16);
        first_c = phase_reg < wph;
        x_c     = first_c ? phase_reg : phase_reg - wph;
        step1   = (PHASE_BITS+2)'(step_reg);
        step2   = step1 << 1;
        step3   = step2 + step1;
        x_ext   = (PHASE_BITS+2)'(x_c);
        if (x_ext < step1)
            seg_c = SEG_RISE;
        else if (x_ext < step2)
            seg_c = SEG_MID;
        else if (x_ext < step3)
            seg_c = SEG_END;
        else
            seg_c = SEG_LINE;
        s_ext   = {step_reg, 32'd0};
        xq_ext  = {x_c, 32'd0};
        dc_c    = 35'(s_ext[PHASE_BITS+31:PHASE_BITS])
                + 35'(s_ext[PHASE_BITS+31:PHASE_BITS+1]);
        xd_c    = 35'(xq_ext[PHASE_BITS+31:PHASE_BITS]) - dc_c;
    end

    // unit requests, operands by state
    always_comb
    begin
        div_state = (state_reg == ST_SLOPE) || (state_reg == ST_CMAG)
                 || (state_reg == ST_UDIV) || (state_reg == ST_FRAC);
        mul_state = (state_reg == ST_LINE) || (state_reg == ST_USQ)
                 || (state_reg == ST_UCUBE) || (state_reg == ST_UQUAD)
                 || (state_reg == ST_CS) || (state_reg == ST_CORR);
        div_start = div_state && !issued_reg;
        mul_start = mul_state && !issued_reg;

        div_num = '0;
        div_den = '0;
        mul_a   = '0;
        mul_b   = '0;
        unique case (state_reg)
            ST_SLOPE:
            begin
                div_num = NUM_BITS'(1) << 49;
                div_den = use_a_reg ? DEN_BITS'(wq_reg)
                                    : DEN_BITS'(17'h10000 - 17'(wq_reg));
            end
            ST_CMAG:
            begin
                div_num = NUM_BITS'(1) << 65;
                div_den = DEN_BITS'(den_reg);
            end
            ST_UDIV:
            begin
                div_num = NUM_BITS'({x_reg, 32'd0});
                div_den = DEN_BITS'(step_reg);
            end
            ST_FRAC:
            begin
                div_num = NUM_BITS'($unsigned(u4_reg));
                div_den = (seg_reg == SEG_MID) ? DEN_BITS'(QUARTIC_DIV_MID)
                                               : DEN_BITS'(QUARTIC_DIV_EDGE);
            end
            ST_LINE:
            begin
                mul_a = slope_reg;
                mul_b = xd_reg;
            end
            ST_USQ:
            begin
                mul_a = u_reg;
                mul_b = u_reg;
            end
            ST_UCUBE:
            begin
                mul_a = u2_reg;
                mul_b = u_reg;
            end
            ST_UQUAD:
            begin
                mul_a = u3_reg;
                mul_b = u_reg;
            end
            ST_CS:
            begin
                mul_a = c_reg;
                mul_b = val_t'($signed({1'b0, s32_reg}));
            end
            ST_CORR:
            begin
                mul_a = cs_reg;
                mul_b = poly_reg;
            end
            default:
            begin
                div_num = '0;
            end
        endcase
        div_q = $signed({1'b0, div_quot[VAL_BITS-2:0]});
    end

    // transition polynomial and output rounding
    always_comb
    begin
        case (seg_reg)
            SEG_RISE:
                poly_c = -t_reg;
            SEG_MID:
                poly_c = t_reg - u3_reg + u2_reg + (u2_reg >>> 1) - u_reg + QUARTER_Q;
            default:
                poly_c = -t_reg + u3_reg - ((u2_reg <<< 2) + (u2_reg >>> 1))
                       + ((u_reg <<< 3) - u_reg) - (QUARTER_Q + QUARTER_Q + QUARTER_Q)
                       - (ONE_Q + ONE_Q + ONE_Q);
        endcase
        rnd_c     = (y_reg + HALF_LSB) >>> RND_SH;
        wave_free = !wave_valid_reg || !wave_stall;
        ctrl_take = ctrl_valid && (state_reg == ST_IDLE);
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (ctrl_take)
                    state_next = ST_PHASE;
            ST_PHASE:
                state_next = ST_SEG;
            ST_SEG:
                state_next = ST_SLOPE;
            ST_SLOPE:
                if (div_done)
                    state_next = ST_LINE;
            ST_LINE:
                if (mul_done)
                    state_next = (seg_reg == SEG_LINE) ? ST_ROUND : ST_CMAG;
            ST_CMAG:
                if (div_done)
                    state_next = ST_UDIV;
            ST_UDIV:
                if (div_done)
                    state_next = ST_USQ;
            ST_USQ:
                if (mul_done)
                    state_next = ST_UCUBE;
            ST_UCUBE:
                if (mul_done)
                    state_next = ST_UQUAD;
            ST_UQUAD:
                if (mul_done)
                    state_next = ST_FRAC;
            ST_FRAC:
                if (div_done)
                    state_next = ST_POLY;
            ST_POLY:
                state_next = ST_CS;
            ST_CS:
                if (mul_done)
                    state_next = ST_CORR;
            ST_CORR:
                if (mul_done)
                    state_next = ST_ROUND;
            ST_ROUND:
                if (wave_free)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // control state, oscillator state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            issued_reg     <= 1'b0;
            phase_reg      <= '0;
            prev_off_reg   <= '0;
            sync_zero_reg  <= 1'b1;
            wave_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (div_start || mul_start)
                issued_reg <= 1'b1;
            else if (div_done || mul_done)
                issued_reg <= 1'b0;
            if (state_reg == ST_PHASE)
            begin
                phase_reg     <= pos_c;
                prev_off_reg  <= ctrl_reg.phase_offset;
                sync_zero_reg <= (ctrl_reg.sync_level == 16'sd0);
            end
            if ((state_reg == ST_ROUND) && wave_free)
                wave_valid_reg <= 1'b1;
            else if (!wave_stall)
                wave_valid_reg <= 1'b0;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (ctrl_take)
            ctrl_reg <= ctrl_data;
        if (state_reg == ST_PHASE)
        begin
            wq_reg   <= wq_c;
            step_reg <= step_c;
        end
        if (state_reg == ST_SEG)
        begin
            first_reg <= first_c;
            x_reg     <= x_c;
            seg_reg   <= seg_c;
            use_a_reg <= (first_c == (seg_c == SEG_LINE));
            cyc_reg   <= phase_reg < step_reg;
            s32_reg   <= s_ext[PHASE_BITS+31:PHASE_BITS];
            den_reg   <= 32'(wq_reg) * (32'h0001_0000 - 32'(wq_reg));
            xd_reg    <= val_t'($signed(xd_c));
        end
        if (div_done)
        begin
            if (state_reg == ST_SLOPE)
                slope_reg <= use_a_reg ? div_q : -div_q;
            if (state_reg == ST_CMAG)
                c_reg <= -div_q;
            if (state_reg == ST_UDIV)
                u_reg <= div_q;
            if (state_reg == ST_FRAC)
                t_reg <= div_q;
        end
        if (mul_done)
        begin
            if (state_reg == ST_LINE)
                y_reg <= mul_res + (first_reg ? -ONE_Q : ONE_Q);
            if (state_reg == ST_USQ)
                u2_reg <= mul_res;
            if (state_reg == ST_UCUBE)
                u3_reg <= mul_res;
            if (state_reg == ST_UQUAD)
                u4_reg <= mul_res;
            if (state_reg == ST_CS)
                cs_reg <= mul_res;
            if (state_reg == ST_CORR)
                y_reg <= first_reg ? y_reg + mul_res : y_reg - mul_res;
        end
        if (state_reg == ST_POLY)
            poly_reg <= poly_c;
        if ((state_reg == ST_ROUND) && wave_free)
        begin
            if (rnd_c > SAT_HI)
                wave_reg.wave_sample <= SAT_HI[OUT_BITS-1:0];
            else if (rnd_c < SAT_LO)
                wave_reg.wave_sample <= SAT_LO[OUT_BITS-1:0];
            else
                wave_reg.wave_sample <= rnd_c[OUT_BITS-1:0];
            wave_reg.cycle_start <= cyc_reg;
        end
    end

    ptri_div #(
        .NUM_BITS (NUM_BITS),
        .DEN_BITS (DEN_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_quot)
    );

    ptri_mul u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mul_start),
        .opa    (mul_a),
        .opb    (mul_b),
        .done   (mul_done),
        .result (mul_res)
    );

    assign ctrl_stall = (state_reg != ST_IDLE);
    assign wave_valid = wave_valid_reg;
    assign wave_data  = wave_reg;

endmodule
